// File: hdl/run_length_threshold_detector_core_defines.svh
// Assertion macros shared by the run-length threshold detector RTL.
`ifndef RUN_LENGTH_THRESHOLD_DETECTOR_CORE_DEFINES_SVH
`define RUN_LENGTH_THRESHOLD_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RLTD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define RLTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rltd_pkg.sv
// Package: widths, register indexes, mode codes and compare helpers for the detector.
`default_nettype none

package rltd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_BITS  = 16;

    localparam int TOL_BITS    = 15;
    localparam int WINDOW_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int MODE_BITS   = 2;

    localparam int DIFF_BITS = SAMPLE_BITS + 1;
    localparam int CMP_BITS  = (DIFF_BITS > TOL_BITS) ? DIFF_BITS : TOL_BITS;

    localparam int CFG_DATA_BITS  = (SAMPLE_BITS > WINDOW_BITS) ? SAMPLE_BITS : WINDOW_BITS;
    localparam int CFG_INDEX_BITS = 3;

    localparam int S_PAYLOAD_BITS = 2 * SAMPLE_BITS + INDEX_BITS;
    localparam int S_TDATA_BITS   = ((S_PAYLOAD_BITS + 7) / 8) * 8;
    localparam int M_PAYLOAD_BITS = 2 * INDEX_BITS;
    localparam int M_TDATA_BITS   = ((M_PAYLOAD_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_QUALIFY_MODE     = 3'd0,
        REG_REPORT_ALL       = 3'd1,
        REG_THRESHOLD_LOW    = 3'd2,
        REG_THRESHOLD_HIGH   = 3'd3,
        REG_THRESHOLD_SECOND = 3'd4,
        REG_TOLERANCE        = 3'd5,
        REG_WINDOW_LENGTH    = 3'd6
    } cfg_reg_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_ABOVE = 2'd0,
        MODE_BOTH  = 2'd1,
        MODE_BAND  = 2'd2
    } qualify_mode_t;

    typedef enum logic {
        STATUS_FOUND    = 1'b0,
        STATUS_NOT_FOUND = 1'b1
    } status_t;

    // Magnitude of x - t below tolerance means equal.
    function automatic logic cmp_equal(input logic signed [SAMPLE_BITS-1:0] x,
                                       input logic signed [SAMPLE_BITS-1:0] t,
                                       input logic [TOL_BITS-1:0] tol);
        logic signed [DIFF_BITS-1:0] d;
        logic [DIFF_BITS-1:0]        mag;
        begin
            d   = DIFF_BITS'(x) - DIFF_BITS'(t);
            mag = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
            return CMP_BITS'(mag) < CMP_BITS'(tol);
        end
    endfunction

    function automatic logic cmp_greater(input logic signed [SAMPLE_BITS-1:0] x,
                                         input logic signed [SAMPLE_BITS-1:0] t,
                                         input logic [TOL_BITS-1:0] tol);
        begin
            return !cmp_equal(x, t, tol) && (x >= t);
        end
    endfunction

    function automatic logic cmp_less(input logic signed [SAMPLE_BITS-1:0] x,
                                      input logic signed [SAMPLE_BITS-1:0] t,
                                      input logic [TOL_BITS-1:0] tol);
        begin
            return !cmp_equal(x, t, tol) && (x < t);
        end
    endfunction

endpackage

`default_nettype wire

// File: hdl/run_length_threshold_detector_core.sv
// Top level: run-length threshold detector over a streamed sensor sample sequence.
//
//  Channel   Dir  Handshake           Contents
//  s_*       in   s_tvalid/s_tready   sample_a, sample_b, sample_index (tdata),
//                                     first_sample (tuser), last_sample (tlast)
//  m_*       out  m_tvalid/m_tready   run_start_index, run_end_index (tdata),
//                                     status (tuser)
//  cfg_*     in   cfg_wr_en           register index and write data, no read-back
//
//  One sample per cycle is accepted, but a stalled result stalls the input
//  register, which stalls s_tready. A sample goes from the input register to
//  the result register through a single compare/count pass of the run state
//  update, so back-to-back samples never wait on each other. Reset (aresetn
//  low, synchronous) empties both registers and clears run state.
`default_nettype none
`include "run_length_threshold_detector_core_defines.svh"

module run_length_threshold_detector_core (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write port
    input  wire logic                               cfg_wr_en,
    input  wire logic [rltd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [rltd_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // sample input
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // low to high: sample_a, sample_b, sample_index, zero pad
    input  wire logic [rltd_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // first_sample
    input  wire logic                               s_tuser,
    input  wire logic                               s_tlast,
    // result output
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // low to high: run_start_index, run_end_index, zero pad
    output logic [rltd_pkg::M_TDATA_BITS-1:0]       m_tdata,
    // status
    output logic                                    m_tuser
);
    import rltd_pkg::*;

    // ---------------- configuration registers ----------------
    logic [MODE_BITS-1:0]          qualify_mode_reg;
    logic                          report_all_reg;
    logic signed [SAMPLE_BITS-1:0] threshold_low_reg;
    logic signed [SAMPLE_BITS-1:0] threshold_high_reg;
    logic signed [SAMPLE_BITS-1:0] threshold_second_reg;
    logic [TOL_BITS-1:0]           tolerance_reg;
    logic [WINDOW_BITS-1:0]        window_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qualify_mode_reg     <= '0;
            report_all_reg       <= 1'b0;
            threshold_low_reg    <= '0;
            threshold_high_reg   <= '0;
            threshold_second_reg <= '0;
            tolerance_reg        <= TOL_BITS'(1);
            window_length_reg    <= WINDOW_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_QUALIFY_MODE:     qualify_mode_reg     <= cfg_wdata[MODE_BITS-1:0];
                REG_REPORT_ALL:       report_all_reg       <= cfg_wdata[0];
                REG_THRESHOLD_LOW:    threshold_low_reg    <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_THRESHOLD_HIGH:   threshold_high_reg   <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_THRESHOLD_SECOND: threshold_second_reg <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_TOLERANCE:        tolerance_reg        <= cfg_wdata[TOL_BITS-1:0];
                REG_WINDOW_LENGTH:    window_length_reg    <= cfg_wdata[WINDOW_BITS-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                          in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_a_reg;
    logic signed [SAMPLE_BITS-1:0] in_b_reg;
    logic [INDEX_BITS-1:0]         in_index_reg;
    logic                          in_first_reg;
    logic                          in_last_reg;

    logic out_free;     // result register can take a new value this cycle
    logic in_fire;      // input register hands its sample to the update pass

    assign in_fire  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_a_reg     <= s_tdata[SAMPLE_BITS-1:0];
            in_b_reg     <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            in_index_reg <= s_tdata[2*SAMPLE_BITS+INDEX_BITS-1:2*SAMPLE_BITS];
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    // ---------------- run state ----------------
    logic [COUNT_BITS-1:0] run_count_reg,  run_count_next;
    logic [INDEX_BITS-1:0] run_origin_reg, run_origin_next;
    logic                  search_done_reg, search_done_next;
    logic                  any_found_reg,   any_found_next;

    logic                  qualifies;
    logic                  gt_low;
    logic [COUNT_BITS-1:0] count_base;
    logic                  done_base;
    logic                  found_base;
    logic [WINDOW_BITS-1:0] window_eff;

    logic                  out_load;
    logic                  out_status_next;
    logic [INDEX_BITS-1:0] out_start_next;
    logic [INDEX_BITS-1:0] out_end_next;

    // Qualify the sample against the active rule.
    always_comb begin
        gt_low = cmp_greater(in_a_reg, threshold_low_reg, tolerance_reg);
        case (qualify_mode_t'(qualify_mode_reg))
            MODE_ABOVE: qualifies = gt_low;
            MODE_BOTH:  qualifies = gt_low &&
                                    cmp_greater(in_b_reg, threshold_second_reg, tolerance_reg);
            MODE_BAND:  qualifies = gt_low &&
                                    cmp_less(in_a_reg, threshold_high_reg, tolerance_reg);
            default:    qualifies = 1'b0;
        endcase
    end

    // Single pass: clear on first sample, count, then report a run or a miss.
    always_comb begin
        window_eff = (window_length_reg == '0) ? WINDOW_BITS'(1) : window_length_reg;

        count_base = in_first_reg ? '0   : run_count_reg;
        done_base  = in_first_reg ? 1'b0 : search_done_reg;
        found_base = in_first_reg ? 1'b0 : any_found_reg;

        run_count_next   = run_count_reg;
        run_origin_next  = run_origin_reg;
        search_done_next = search_done_reg;
        any_found_next   = any_found_reg;

        out_load        = 1'b0;
        out_status_next = STATUS_FOUND;
        out_start_next  = '0;
        out_end_next    = '0;

        if (in_fire) begin
            run_count_next   = count_base;
            search_done_next = done_base;
            any_found_next   = found_base;

            if (!done_base) begin
                // advance or break the run
                if (qualifies) begin
                    if (count_base == '0) begin
                        run_origin_next = in_index_reg;
                    end
                    if (count_base != COUNT_MAX) begin
                        run_count_next = count_base + COUNT_BITS'(1);
                    end
                end else begin
                    run_count_next = '0;
                end

                if (WINDOW_BITS'(run_count_next) >= window_eff) begin
                    out_load        = 1'b1;
                    out_status_next = STATUS_FOUND;
                    out_start_next  = run_origin_next;
                    out_end_next    = in_index_reg;
                    if (report_all_reg) begin
                        any_found_next = 1'b1;
                        run_count_next = '0;
                    end else begin
                        search_done_next = 1'b1;
                    end
                    if (in_last_reg) begin
                        search_done_next = 1'b1;
                    end
                end else if (in_last_reg) begin
                    search_done_next = 1'b1;
                    if (!found_base) begin
                        out_load        = 1'b1;
                        out_status_next = STATUS_NOT_FOUND;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_count_reg   <= '0;
            run_origin_reg  <= '0;
            search_done_reg <= 1'b0;
            any_found_reg   <= 1'b0;
        end else begin
            run_count_reg   <= run_count_next;
            run_origin_reg  <= run_origin_next;
            search_done_reg <= search_done_next;
            any_found_reg   <= any_found_next;
        end
    end

    // ---------------- result register ----------------
    logic                  m_valid_reg;
    logic                  m_status_reg;
    logic [INDEX_BITS-1:0] m_start_reg;
    logic [INDEX_BITS-1:0] m_end_reg;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= out_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= out_status_next;
            m_start_reg  <= out_start_next;
            m_end_reg    <= out_end_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_TDATA_BITS'({m_end_reg, m_start_reg});

    // ---------------- assertions ----------------
    `RLTD_ASSERT_IMPLY(a_no_overwrite, m_valid_reg && !m_tready, !out_load, "result overwritten while stalled")
    `RLTD_ASSERT_IMPLY(a_done_silent, in_fire && search_done_reg && !in_first_reg, !out_load, "result after search done")
    `RLTD_ASSERT_IMPLY(a_miss_on_last, out_load && out_status_next, in_last_reg, "not-found result off last sample")
    `RLTD_ASSERT_NEXT(a_restart_count, out_load && !out_status_next && report_all_reg, run_count_reg == '0, "run count not restarted")

endmodule

`default_nettype wire
